>>> hw/rtl/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, constants and helpers of the case folding substring finder.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

    // defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // register file geometry: 64-bit registers at byte address 8*i
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 5;
    localparam int PAT_SLOTS = 16;
    localparam int LEN_REG_W = 5;
    localparam int RESULT_W = 32;

    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2,
        REG_FOLD     = 2'd3
    } t_reg_idx;

    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] FOLD_DELTA  = 8'h20;

    typedef struct packed {
        logic [DATA_W-1:0]    pat_low;
        logic [DATA_W-1:0]    pat_high;
        logic [LEN_REG_W-1:0] pat_len;
        logic                 fold;
    } t_cfg;

    typedef struct packed {
        logic                found;
        logic [RESULT_W-1:0] offset;
    } t_result;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= UPPER_FIRST) && (b <= UPPER_LAST)) begin
            r = b + FOLD_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/csf_cfg_regs.sv
// ----------------------------------------------------------------------------
// csf_cfg_regs
// APB-style register file holding the pattern, its length and the fold flag.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_cfg_regs
    import csf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_PAT_LOW:  n_cfg.pat_low  = pwdata;
                REG_PAT_HIGH: n_cfg.pat_high = pwdata;
                REG_PAT_LEN:  n_cfg.pat_len  = pwdata[LEN_REG_W-1:0];
                REG_FOLD:     n_cfg.fold     = pwdata[0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PAT_LOW:  prdata = r_cfg.pat_low;
            REG_PAT_HIGH: prdata = r_cfg.pat_high;
            REG_PAT_LEN:  prdata = {{(DATA_W-LEN_REG_W){1'b0}}, r_cfg.pat_len};
            REG_FOLD:     prdata = {{(DATA_W-1){1'b0}}, r_cfg.fold};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/csf_matcher.sv
// ----------------------------------------------------------------------------
// csf_matcher
// Byte window, offset counter and parallel window compare against the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_matcher
    import csf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_last_byte,
    output logic            o_push,
    output t_result         o_result
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int WIN_D = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int IDX_W = $clog2(PAT_SLOTS);

    logic [7:0]             r_win [WIN_D];
    logic [7:0]             w_view [PATTERN_MAX];
    logic [7:0]             w_pat [PAT_SLOTS];
    logic [7:0]             w_aligned [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_eq;
    logic [LEN_W-1:0]       w_len;
    logic [OFFSET_BITS-1:0] r_seen;
    logic [OFFSET_BITS-1:0] n_seen;
    logic [OFFSET_BITS-1:0] w_start;
    logic                   r_matched;
    logic                   n_matched;
    logic                   w_sat;
    logic                   w_enough;
    logic                   w_hit;
    logic                   w_end_miss;

    // length above the window depth saturates
    always_comb begin
        if (i_cfg.pat_len > LEN_REG_W'(PATTERN_MAX)) begin
            w_len = LEN_W'(PATTERN_MAX);
        end else begin
            w_len = LEN_W'(i_cfg.pat_len);
        end
    end

    always_comb begin
        for (int i = 0; i < PAT_SLOTS / 2; i++) begin
            w_pat[i]                 = i_cfg.pat_low[8*i +: 8];
            w_pat[i + PAT_SLOTS / 2] = i_cfg.pat_high[8*i +: 8];
        end
    end

    // newest byte at position 0; pattern reversed so that position k meets
    // pattern byte len-1-k
    always_comb begin
        logic [IDX_W-1:0] idx;
        w_view[0] = i_text_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            w_view[k] = r_win[k-1];
        end
        for (int k = 0; k < PATTERN_MAX; k++) begin
            idx          = IDX_W'(LEN_W'(w_len - LEN_W'(k) - LEN_W'(1)));
            w_aligned[k] = fold_byte(w_pat[idx], i_cfg.fold);
            w_eq[k]      = (LEN_W'(k) >= w_len) ||
                           (fold_byte(w_view[k], i_cfg.fold) == w_aligned[k]);
        end
    end

    assign w_sat    = &r_seen;
    assign w_enough = w_sat ||
                      (({1'b0, r_seen} + (OFFSET_BITS+1)'(1)) >=
                       (OFFSET_BITS+1)'(w_len));
    assign w_hit    = !r_matched && w_enough && (&w_eq);
    assign w_end_miss = i_last_byte && !r_matched && !w_hit;

    always_comb begin
        if (w_len == '0) begin
            w_start = '0;
        end else if (w_sat) begin
            w_start = r_seen;
        end else begin
            w_start = r_seen + OFFSET_BITS'(1) - OFFSET_BITS'(w_len);
        end
    end

    assign o_push          = i_accept && (w_hit || w_end_miss);
    assign o_result.found  = w_hit;
    assign o_result.offset = w_hit ? RESULT_W'(w_start) : '0;

    always_comb begin
        n_seen    = r_seen;
        n_matched = r_matched;
        if (i_accept) begin
            if (i_last_byte) begin
                n_seen    = '0;
                n_matched = 1'b0;
            end else begin
                n_seen    = w_sat ? r_seen : r_seen + OFFSET_BITS'(1);
                n_matched = r_matched || w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_matched <= 1'b0;
        end else begin
            r_seen    <= n_seen;
            r_matched <= n_matched;
        end
    end

    // window contents beyond the bytes of the current text are never compared
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win[0] <= i_text_byte;
            for (int k = 1; k < WIN_D; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/csf_out_buf.sv
// ----------------------------------------------------------------------------
// csf_out_buf
// Result register with a skid slot behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_out_buf
    import csf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_result
);

    logic    r_main_valid;
    logic    n_main_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_main;
    t_result n_main;
    t_result r_skid;
    t_result n_skid;
    logic    w_take;

    assign w_take   = r_main_valid && !i_stall;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;
    assign o_full   = r_skid_valid;

    // a push only comes while the skid slot is empty
    always_comb begin
        n_main       = r_main;
        n_skid       = r_skid;
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        if (w_take || !r_main_valid) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
            end else begin
                n_main       = i_result;
                n_main_valid = i_push;
            end
            n_skid_valid = 1'b0;
        end else if (!r_skid_valid && i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

>>> hw/rtl/case_folding_substring_finder.sv
// ----------------------------------------------------------------------------
// case_folding_substring_finder
// Streams text bytes and reports the first match of a configured pattern.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one text byte per transfer,
// with i_last_byte set on the final byte of a text. Output channel:
// o_out_valid / i_out_stall carry one result per text: o_found set with the
// start offset of the first match, or o_found clear when the text ended
// without one. Bytes are taken one per cycle while o_in_stall is low; the
// window compare against the pattern is a single parallel pass, so throughput
// is one byte per cycle unless stalled. Results are registered in the output
// buffer, which has a result register plus one skid slot; o_in_stall is set
// while both hold results, so a stalled receiver holds up the text only
// after two pending results. The pattern, its length (saturated to
// PATTERN_MAX) and the fold flag are written over the APB-style port at byte
// addresses 0, 8, 16 and 24; the user must write them only while no text is
// in progress, which the block does not enforce. Reset clears registers,
// offset counter and both output slots; bytes can be taken once reset ends.
// ----------------------------------------------------------------------------
`default_nettype none

module case_folding_substring_finder
    import csf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [7:0]          i_text_byte,
    input  wire logic                i_last_byte,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_found,
    output logic      [RESULT_W-1:0] o_match_offset
);

    t_cfg    w_cfg;
    t_result w_new;
    t_result w_out;
    logic    w_push;
    logic    w_full;
    logic    w_accept;

    assign w_accept       = i_in_valid && !w_full;
    assign o_in_stall     = w_full;
    assign o_found        = w_out.found;
    assign o_match_offset = w_out.offset;

    csf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    csf_matcher #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_accept    (w_accept),
        .i_text_byte (i_text_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_result    (w_new)
    );

    csf_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_new),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_out)
    );

endmodule

`default_nettype wire
